>>> rtl/core/zfts_pkg.sv
// Shared types, character codes and result helpers for the zone file token scanner.
// No dependencies; imported by every module of the block.
package zfts_pkg;

   localparam int MAX_RES     = 4;
   localparam int QUEUE_DEPTH = 2;
   localparam int CNT_W       = $clog2(MAX_RES + 1);
   localparam int SLOT_W      = $clog2(MAX_RES);
   localparam int ESC_W       = 10;
   localparam int DIGIT_W     = 2;

   localparam logic [DIGIT_W-1:0] ESC_DIGITS = 2'd3;

   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_OPEN   = 8'h28;
   localparam logic [7:0] CH_CLOSE  = 8'h29;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_BSLASH = 8'h5C;

   typedef enum logic [2:0] {
      K_BYTE       = 3'd0,
      K_END        = 3'd1,
      K_NEWLINE    = 3'd2,
      K_SPACE      = 3'd3,
      K_STREAM_END = 3'd4
   } kind_type;

   typedef enum logic [3:0] {
      LEX_NORMAL  = 4'b0001,
      LEX_COMMENT = 4'b0010,
      LEX_QUOTE   = 4'b0100,
      LEX_ESCAPE  = 4'b1000
   } lex_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] value;
   } slot_type;

   // All results caused by one input beat, in delivery order
   typedef struct packed {
      slot_type [MAX_RES-1:0] slots;
      logic                   err;
      logic [CNT_W-1:0]       count;
   } bundle_type;

   function automatic bundle_type put_result(bundle_type b, kind_type k, logic [7:0] v);
      bundle_type r;
      r = b;
      if (r.count < CNT_W'(MAX_RES)) begin
         r.slots[r.count[SLOT_W-1:0]] = slot_type'{kind: k, value: v};
         r.count = r.count + 1'b1;
      end
      return r;
   endfunction

   // Token end if one is open, then a newline or (unless skipped) a space
   function automatic bundle_type put_break(bundle_type b, logic tok, logic as_space,
                                            logic skip);
      bundle_type r;
      r = b;
      if (tok) begin
         r = put_result(r, K_END, 8'd0);
      end
      if (as_space) begin
         if (!skip) begin
            r = put_result(r, K_SPACE, 8'd0);
         end
      end else begin
         r = put_result(r, K_NEWLINE, 8'd0);
      end
      return r;
   endfunction

endpackage

>>> rtl/core/zfts_front.sv
// Front end: accepts input beats, runs the lexer state and builds the result bundle.
// Depends on zfts_pkg; feeds zfts_queue.
module zfts_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_end_of_stream,
   input  logic                 csr_wr_en,
   input  logic                 csr_wr_data,
   output logic                 push_valid,
   input  logic                 push_ready,
   output zfts_pkg::bundle_type push_data
);
   import zfts_pkg::*;

   logic               skip_ff, skip_in;
   logic               tok_ff, tok_in;
   logic               cont_ff, cont_in;
   lex_type            mode_ff, mode_in;
   logic [DIGIT_W-1:0] dc_ff, dc_in;
   logic [ESC_W-1:0]   ev_ff, ev_in;

   bundle_type         bun;
   logic               accept;
   logic               digit;
   logic               scan;
   logic [ESC_W-1:0]   dval;
   logic [7:0]         c;

   assign c      = req_data_byte;
   assign accept = req_valid && push_ready;
   assign digit  = (c >= CH_ZERO) && (c <= CH_NINE);
   assign dval   = {{(ESC_W-4){1'b0}}, c[3:0]};

   always_comb begin
      bun     = '0;
      tok_in  = tok_ff;
      cont_in = cont_ff;
      mode_in = mode_ff;
      dc_in   = dc_ff;
      ev_in   = ev_ff;
      scan    = 1'b0;
      if (req_end_of_stream) begin
         if (mode_ff == LEX_ESCAPE) begin
            bun = put_result(bun, K_BYTE, ev_ff[7:0]);
         end else if (mode_ff == LEX_COMMENT) begin
            bun    = put_break(bun, tok_in, cont_ff, skip_ff);
            tok_in = 1'b0;
         end
         mode_in = LEX_NORMAL;
         dc_in   = '0;
         ev_in   = '0;
         bun.err = cont_ff;
         cont_in = 1'b0;
         if (tok_in) begin
            bun    = put_result(bun, K_END, 8'd0);
            bun    = put_result(bun, K_NEWLINE, 8'd0);
            tok_in = 1'b0;
         end
         bun = put_result(bun, K_STREAM_END, 8'd0);
      end else begin
         case (mode_ff)
            LEX_COMMENT: begin
               if (c == CH_LF) begin
                  mode_in = LEX_NORMAL;
                  bun     = put_break(bun, tok_in, cont_ff, skip_ff);
                  tok_in  = 1'b0;
               end
            end
            LEX_QUOTE: begin
               if (digit) begin
                  ev_in   = dval;
                  dc_in   = 2'd1;
                  mode_in = LEX_ESCAPE;
               end else begin
                  bun     = put_result(bun, K_BYTE, c);
                  mode_in = LEX_NORMAL;
               end
            end
            LEX_ESCAPE: begin
               if (digit) begin
                  ev_in = (ev_ff << 3) + (ev_ff << 1) + dval;
                  dc_in = dc_ff + 1'b1;
                  if (dc_in >= ESC_DIGITS) begin
                     bun     = put_result(bun, K_BYTE, ev_in[7:0]);
                     mode_in = LEX_NORMAL;
                     dc_in   = '0;
                     ev_in   = '0;
                  end
               end else begin
                  // non-digit closes the escape and is then scanned as usual
                  bun     = put_result(bun, K_BYTE, ev_ff[7:0]);
                  mode_in = LEX_NORMAL;
                  dc_in   = '0;
                  ev_in   = '0;
                  scan    = 1'b1;
               end
            end
            default: begin
               scan = 1'b1;
            end
         endcase

         if (scan) begin
            case (c)
               CH_TAB, CH_SPACE: begin
                  bun    = put_break(bun, tok_in, 1'b1, skip_ff);
                  tok_in = 1'b0;
               end
               CH_LF, CH_FF, CH_CR: begin
                  bun    = put_break(bun, tok_in, cont_ff, skip_ff);
                  tok_in = 1'b0;
               end
               CH_SEMI: begin
                  mode_in = LEX_COMMENT;
               end
               CH_OPEN: begin
                  cont_in = 1'b1;
               end
               CH_CLOSE: begin
                  cont_in = 1'b0;
               end
               CH_BSLASH: begin
                  bun     = put_result(bun, K_BYTE, c);
                  tok_in  = 1'b1;
                  mode_in = LEX_QUOTE;
               end
               default: begin
                  bun    = put_result(bun, K_BYTE, c);
                  tok_in = 1'b1;
               end
            endcase
         end
      end
   end

   assign skip_in    = csr_wr_en ? csr_wr_data : skip_ff;
   assign req_ready  = push_ready;
   assign push_valid = accept && (bun.count != '0);
   assign push_data  = bun;

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff <= 1'b1;
         tok_ff  <= 1'b0;
         cont_ff <= 1'b0;
         mode_ff <= LEX_NORMAL;
         dc_ff   <= '0;
         ev_ff   <= '0;
      end else begin
         skip_ff <= skip_in;
         if (accept) begin
            tok_ff  <= tok_in;
            cont_ff <= cont_in;
            mode_ff <= mode_in;
            dc_ff   <= dc_in;
            ev_ff   <= ev_in;
         end
      end
   end

`ifndef SYNTHESIS
   // end of stream always leaves the lexer at its start state
   assert property (@(posedge clock) disable iff (reset)
      accept && req_end_of_stream |=> mode_ff == LEX_NORMAL && !cont_ff && !tok_ff)
      else $error("lexer state not cleared after end of stream");

   // escape digit counter only runs inside a decimal escape
   assert property (@(posedge clock) disable iff (reset)
      mode_ff != LEX_ESCAPE |-> dc_ff == '0)
      else $error("digit count live outside escape");

   // the stream-end result always carries the bundle's last slot
   assert property (@(posedge clock) disable iff (reset)
      accept && req_end_of_stream |-> push_valid && bun.count != '0 &&
         bun.slots[bun.count[SLOT_W-1:0] - 1'b1].kind == K_STREAM_END)
      else $error("stream end not last in bundle");
`endif

endmodule

>>> rtl/core/zfts_queue.sv
// Small register queue of result bundles between the front and back ends.
// Depends on zfts_pkg for the bundle type.
module zfts_queue #(
   parameter int Depth = zfts_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  zfts_pkg::bundle_type push_data,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output zfts_pkg::bundle_type pop_data
);
   import zfts_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   bundle_type      entries_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            push, pop;

   assign push_ready = count_ff != CntW'(Depth);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("queue overfilled");

   // pointers are equal exactly when the queue is empty or full
   assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff == rd_ptr_ff) == (count_ff == '0 || count_ff == CntW'(Depth)))
      else $error("queue pointers disagree with count");

   // nothing empty is ever queued
   assert property (@(posedge clock) disable iff (reset)
      push |-> push_data.count != '0)
      else $error("empty bundle pushed");
`endif

endmodule

>>> rtl/core/zfts_back.sv
// Back end: takes bundles from the queue and hands out their results one beat a cycle while rsp_ready is high.
// Depends on zfts_pkg.
module zfts_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  zfts_pkg::bundle_type pop_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [2:0]           rsp_kind,
   output logic [7:0]           rsp_value,
   output logic                 rsp_continuation_error,
   output logic                 rsp_last
);
   import zfts_pkg::*;

   bundle_type        cur_ff, cur_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic              busy_ff, busy_in;
   logic              at_last;
   logic              take;
   logic              load;
   slot_type          slot;

   assign at_last   = {1'b0, idx_ff} == (cur_ff.count - 1'b1);
   assign take      = busy_ff && rsp_ready;
   assign load      = pop_valid && (!busy_ff || (take && at_last));
   assign pop_ready = load;
   assign slot      = cur_ff.slots[idx_ff];

   assign rsp_valid              = busy_ff;
   assign rsp_kind               = slot.kind;
   assign rsp_value              = slot.value;
   assign rsp_last               = at_last;
   assign rsp_continuation_error = cur_ff.err && at_last;

   always_comb begin
      cur_in  = cur_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;
      if (load) begin
         cur_in  = pop_data;
         idx_in  = '0;
         busy_in = 1'b1;
      end else if (take) begin
         if (at_last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cur_ff.count != '0 && {1'b0, idx_ff} < cur_ff.count)
      else $error("slot index beyond bundle");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == K_STREAM_END |-> rsp_last)
      else $error("stream end beat not marked last");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_continuation_error |-> rsp_kind == K_STREAM_END)
      else $error("error flag on a non stream-end beat");
`endif

endmodule

>>> rtl/core/zone_file_token_scanner_unit.sv
// Zone file token scanner: splits master-file text into token bytes, token ends,
// newline, space and stream-end beats. Depends on zfts_pkg, zfts_front, zfts_queue, zfts_back.
//
// Usage:
//   req_*  : one character (req_data_byte) or an end-of-stream mark per beat,
//            valid/ready handshake.
//   rsp_*  : result beats, valid/ready; rsp_last flags the final result caused by
//            an input beat. An input beat may cause no result ('(' , ')', comment
//            text, skipped spaces) or up to four.
//   csr_*  : csr_wr_en with csr_wr_data sets skip_spaces; write only while idle.
// Path: the bundle is written to the queue at the accepting edge, then loaded into the
//   back-end result register once that is free; rsp_valid comes from that register, and
//   the first result is taken from it.
// Throughput: one input beat per cycle while each beat gives at most one result and
//   rsp_ready stays high; a beat giving N results holds the result port until all N
//   are taken, set by the single result register in the back end.
// The front end classifies and queues result bundles (QueueDepth entries), so
// input keeps flowing while the receiver stalls until the queue fills; then
// req_ready drops.
// Reset: lexer state cleared, skip_spaces set to 1, queue and output emptied.
module zone_file_token_scanner_unit #(
   parameter int QueueDepth = zfts_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_stream,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_kind,
   output logic [7:0] rsp_value,
   output logic       rsp_continuation_error,
   output logic       rsp_last,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);
   import zfts_pkg::*;

   logic       push_valid, push_ready;
   bundle_type push_data;
   logic       pop_valid, pop_ready;
   bundle_type pop_data;

   zfts_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_end_of_stream (req_end_of_stream),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .push_valid        (push_valid),
      .push_ready        (push_ready),
      .push_data         (push_data)
   );

   zfts_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   zfts_back u_back (
      .clock                  (clock),
      .reset                  (reset),
      .pop_valid              (pop_valid),
      .pop_ready              (pop_ready),
      .pop_data               (pop_data),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_kind               (rsp_kind),
      .rsp_value              (rsp_value),
      .rsp_continuation_error (rsp_continuation_error),
      .rsp_last               (rsp_last)
   );

endmodule

>>> bench/tb_zone_file_token_scanner_unit.sv
// Self-checking bench for zone_file_token_scanner_unit: directed and random text beats,
// predicted token stream checked in order. Depends on zfts_pkg and the scanner RTL.
module tb_zone_file_token_scanner_unit;
   import zfts_pkg::*;

   localparam logic [8:0] EOS_MARK = 9'h100;
   localparam int IDLE_PCT         = 18;
   localparam int HOLD_CYCLES      = 80;
   localparam int QUIET_LIMIT      = 1000;

   typedef struct {
      kind_type   kind;
      logic [7:0] value;
      logic       err;
      logic       last;
   } token_beat_type;

   class scanner_scoreboard;
      token_beat_type pending_tokens[$];
      token_beat_type step_tokens[$];
      bit          skip_spaces;
      bit          in_token;
      bit          continuation;
      lex_type     mode;
      logic [1:0]  digit_count;
      logic [9:0]  escape_value;
      int          errors;

      function new();
         skip_spaces = 1'b1;
         in_token = 1'b0;
         continuation = 1'b0;
         mode = LEX_NORMAL;
         digit_count = '0;
         escape_value = '0;
         errors = 0;
      endfunction

      function int pending();
         return pending_tokens.size();
      endfunction

      function void emit(kind_type k, logic [7:0] v, logic e);
         token_beat_type t;
         if (step_tokens.size() < MAX_RES) begin
            t.kind = k;
            t.value = v;
            t.err = e;
            t.last = 1'b0;
            step_tokens.push_back(t);
         end
      endfunction

      function void line_break(bit as_space);
         if (in_token) begin
            emit(K_END, 8'd0, 1'b0);
            in_token = 1'b0;
         end
         if (as_space) begin
            if (!skip_spaces) emit(K_SPACE, 8'd0, 1'b0);
         end else begin
            emit(K_NEWLINE, 8'd0, 1'b0);
         end
      endfunction

      function void flush_escape();
         emit(K_BYTE, escape_value[7:0], 1'b0);
         mode = LEX_NORMAL;
         digit_count = '0;
         escape_value = '0;
      endfunction

      function void scan_char(logic [7:0] c);
         case (c)
            CH_TAB, CH_SPACE: line_break(1'b1);
            CH_LF, CH_FF, CH_CR: line_break(continuation);
            CH_SEMI: mode = LEX_COMMENT;
            CH_OPEN: continuation = 1'b1;
            CH_CLOSE: continuation = 1'b0;
            CH_BSLASH: begin
               emit(K_BYTE, c, 1'b0);
               in_token = 1'b1;
               mode = LEX_QUOTE;
            end
            default: begin
               emit(K_BYTE, c, 1'b0);
               in_token = 1'b1;
            end
         endcase
      endfunction

      function void note_char(logic [7:0] c, logic eos);
         bit digit;
         bit err_flag;
         step_tokens.delete();
         digit = (c >= CH_ZERO) && (c <= CH_NINE);
         if (eos) begin
            if (mode == LEX_ESCAPE) flush_escape();
            else if (mode == LEX_COMMENT) line_break(continuation);
            mode = LEX_NORMAL;
            digit_count = '0;
            escape_value = '0;
            err_flag = continuation;
            continuation = 1'b0;
            if (in_token) begin
               emit(K_END, 8'd0, 1'b0);
               in_token = 1'b0;
               emit(K_NEWLINE, 8'd0, 1'b0);
            end
            emit(K_STREAM_END, 8'd0, err_flag);
         end else begin
            case (mode)
               LEX_COMMENT: begin
                  // only LF closes a comment; CR and formfeed are swallowed
                  if (c == CH_LF) begin
                     mode = LEX_NORMAL;
                     line_break(continuation);
                  end
               end
               LEX_QUOTE: begin
                  if (digit) begin
                     escape_value = 10'(c - CH_ZERO);
                     digit_count = 2'd1;
                     mode = LEX_ESCAPE;
                  end else begin
                     emit(K_BYTE, c, 1'b0);
                     mode = LEX_NORMAL;
                  end
               end
               LEX_ESCAPE: begin
                  if (digit) begin
                     escape_value = escape_value * 10'd10 + 10'(c - CH_ZERO);
                     digit_count = digit_count + 2'd1;
                     if (digit_count >= ESC_DIGITS) flush_escape();
                  end else begin
                     // early end of the escape; this byte is then scanned as usual
                     flush_escape();
                     scan_char(c);
                  end
               end
               default: scan_char(c);
            endcase
         end
         if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
         foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_token(logic [2:0] kind, logic [7:0] value, logic err, logic last);
         token_beat_type t;
         if (pending_tokens.size() == 0) begin
            report($sformatf("unexpected beat kind=%0d value=%02h", kind, value));
         end else begin
            t = pending_tokens.pop_front();
            if (kind !== 3'(t.kind))
               report($sformatf("kind %0d, want %0d", kind, t.kind));
            if (value !== t.value)
               report($sformatf("value %02h, want %02h", value, t.value));
            if (err !== t.err)
               report($sformatf("continuation_error %b, want %b", err, t.err));
            if (last !== t.last)
               report($sformatf("last %b, want %b", last, t.last));
         end
      endtask
   endclass

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_data_byte;
   logic       req_end_of_stream;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [2:0] rsp_kind;
   logic [7:0] rsp_value;
   logic       rsp_continuation_error;
   logic       rsp_last;
   logic       csr_wr_en;
   logic       csr_wr_data;

   scanner_scoreboard sb;
   bit steady   = 1'b0;
   bit hold_rsp = 1'b0;

   zone_file_token_scanner_unit DUT (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_data_byte          (req_data_byte),
      .req_end_of_stream      (req_end_of_stream),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_kind               (rsp_kind),
      .rsp_value              (rsp_value),
      .rsp_continuation_error (rsp_continuation_error),
      .rsp_last               (rsp_last),
      .csr_wr_en              (csr_wr_en),
      .csr_wr_data            (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // result side: check every accepted beat, random backpressure, long hold on request
   initial begin : rsp_side
      int hold_left;
      hold_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            sb.check_token(rsp_kind, rsp_value, rsp_continuation_error, rsp_last);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("tb_zone_file_token_scanner_unit NOT OK");
      $finish;
   end

   task automatic send_char(logic [7:0] c, logic eos);
      int n;
      if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         n = $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= c;
      req_end_of_stream <= eos;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_char(c, eos);
   endtask

   task automatic send_text(logic [8:0] text[$]);
      foreach (text[i]) send_char(text[i][7:0], text[i][8]);
   endtask

   task automatic set_skip_spaces(bit v);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      // beats that yield nothing may still be in flight
      repeat (6) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.skip_spaces = v;
   endtask

   function automatic logic [7:0] pick_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 36) return 8'($urandom_range(8'h61, 8'h7A));
      if (r < 48) return 8'($urandom_range(CH_ZERO, CH_NINE));
      if (r < 55) return CH_SPACE;
      if (r < 58) return CH_TAB;
      if (r < 63) return CH_LF;
      if (r < 65) return CH_CR;
      if (r < 66) return CH_FF;
      if (r < 70) return CH_SEMI;
      if (r < 74) return CH_OPEN;
      if (r < 78) return CH_CLOSE;
      if (r < 86) return CH_BSLASH;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic random_text(int count, bit with_hold);
      for (int i = 0; i < count; i++) begin
         if (with_hold && i == count / 3) hold_rsp = 1'b1;
         if ($urandom_range(0, 99) < 2) send_char(8'($urandom_range(0, 255)), 1'b1);
         else send_char(pick_char(), 1'b0);
      end
   endtask

   initial begin : stimulus
      logic [8:0] skip_text[$];
      logic [8:0] space_text[$];
      skip_text = '{9'h061, 9'h0FF, {1'b0, CH_TAB}, 9'h062, {1'b0, CH_OPEN}, 9'h063,
                    {1'b0, CH_CR}, {1'b0, CH_CLOSE}, {1'b0, CH_FF}, {1'b0, CH_SEMI}, 9'h078,
                    {1'b0, CH_CR}, {1'b0, CH_LF}, {1'b0, CH_BSLASH}, 9'h039, 9'h039, 9'h039,
                    {1'b0, CH_BSLASH}, 9'h031, 9'h07A, {1'b0, CH_BSLASH}, EOS_MARK};
      space_text = '{9'h000, {1'b0, CH_BSLASH}, 9'h080, {1'b0, CH_SPACE}, {1'b0, CH_OPEN},
                     {1'b0, CH_BSLASH}, 9'h034, EOS_MARK | 9'h0FF, {1'b0, CH_SEMI}, EOS_MARK};
      sb = new();
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data_byte <= 8'd0;
      req_end_of_stream <= 1'b0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_text(skip_text);
      set_skip_spaces(1'b0);
      send_text(space_text);
      steady = 1'b1;
      random_text(60, 1'b0);
      steady = 1'b0;
      random_text(80, 1'b0);
      set_skip_spaces(1'b1);
      random_text(140, 1'b1);
      set_skip_spaces(1'b0);
      random_text(110, 1'b1);

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.errors == 0) $display("tb_zone_file_token_scanner_unit OK");
      else $display("tb_zone_file_token_scanner_unit NOT OK");
      $finish;
   end

endmodule
